### hw/rtl/bbc_pkg.sv
package bbc_pkg;

  // Status codes carried by every result.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_UNCLOSED = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // One input request: a byte of source text and the end marker.
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_t;

  // One result.
  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] line_number;
    logic [8:0]  depth;
  } out_t;

endpackage

### hw/rtl/bracket_balance_checker.sv
// Channel  Direction  Handshake                 Payload
// in       request    in_valid_i / in_stall_o   in_data_i  (bbc_pkg::in_t)
// out      result     out_valid_o / out_stall_i out_data_o (bbc_pkg::out_t)
//
// One byte is taken per cycle while in_stall_o is low; its result is registered
// into the output register, or waits in the skid entry while an earlier result is still stalled there.
// The rate is set by the stack RAM read loop: the entry below the top is
// prefetched every cycle, so pushes and pops can follow each other freely.
// Reset clears the lexer, stack pointer, line count and error; stack RAM
// contents are not cleared and need no clearing pass.
// in_stall_o rises only once the output register and its skid entry are full.
module bracket_balance_checker #(
  parameter int STACK_ENTRIES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bbc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bbc_pkg::out_t out_data_o
);

  import bbc_pkg::*;

  localparam int AW = $clog2(STACK_ENTRIES);

  logic          accept;
  logic          buf_full;
  out_t          res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [1:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [1:0]    ram_rdata;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  // Lexer and stack control.
  bbc_core #(
    .STACK_ENTRIES(STACK_ENTRIES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (in_data_i),
    .res_o      (res),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  // Bracket kind stack.
  bbc_ram #(
    .WIDTH(2),
    .DEPTH(STACK_ENTRIES)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Result buffering.
  bbc_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(accept),
    .res_i      (res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // The input is only held off while a result is waiting downstream.
  a_stall_needs_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // An overflow can only be reported with the stack completely full.
  a_overflow_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res.status == ST_OVERFLOW |-> res.depth == 9'(STACK_ENTRIES))
    else $error("overflow reported below full depth");

  // A result is presented in the cycle after its request is taken.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request produced no result");

endmodule

### hw/rtl/bbc_ram.sv
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bbc_core.sv
module bbc_core #(
  parameter int STACK_ENTRIES = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  bbc_pkg::in_t                     req_i,
  output bbc_pkg::out_t                    res_o,
  output logic                             ram_we_o,
  output logic [$clog2(STACK_ENTRIES)-1:0] ram_waddr_o,
  output logic [1:0]                       ram_wdata_o,
  output logic [$clog2(STACK_ENTRIES)-1:0] ram_raddr_o,
  input  logic [1:0]                       ram_rdata_i
);

  import bbc_pkg::*;

  localparam int AW  = $clog2(STACK_ENTRIES);
  localparam int SPW = $clog2(STACK_ENTRIES + 1);

  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  typedef enum logic [4:0] {
    LEX_NORMAL  = 5'b00001,
    LEX_SQUOTE  = 5'b00010,
    LEX_DQUOTE  = 5'b00100,
    LEX_DIRECT  = 5'b01000,
    LEX_COMMENT = 5'b10000
  } lex_mode_e;

  lex_mode_e        mode_q, mode_d;
  logic [7:0]       prev_q, prev_d;
  logic [SPW-1:0]   sp_q, sp_d;
  logic [23:0]      line_q, line_d;
  logic [1:0]       held_q, held_d;
  logic [1:0]       top_q, top_d;
  logic [1:0]       ok_kind_w;

  function automatic logic [1:0] opener_kind(input logic [7:0] c);
    logic [1:0] k;
    case (c)
      CH_LPAR: k = 2'd0;
      CH_LBRK: k = 2'd1;
      CH_LBRC: k = 2'd2;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] closer_kind(input logic [7:0] c);
    logic [1:0] k;
    case (c)
      CH_RPAR: k = 2'd0;
      CH_RBRK: k = 2'd1;
      CH_RBRC: k = 2'd2;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Per-byte update. The top of stack lives in top_q; the RAM holds every
  // pushed entry, and the entry under the top is prefetched each cycle so a
  // pop can follow any operation in the next cycle. A push writes at sp while
  // the prefetch reads at sp - 1, so the two ports never meet on one entry.
  always_comb begin
    logic [1:0] ok_kind;
    logic [1:0] cl_kind;
    logic       normal;
    logic [1:0] status;

    ok_kind  = opener_kind(req_i.ch);
    cl_kind  = closer_kind(req_i.ch);
    normal   = !(mode_q inside {LEX_SQUOTE, LEX_DQUOTE, LEX_DIRECT, LEX_COMMENT});
    mode_d   = mode_q;
    prev_d   = prev_q;
    sp_d     = sp_q;
    line_d   = line_q;
    held_d   = held_q;
    top_d    = top_q;
    ram_we_o = 1'b0;
    status   = held_q;

    if (accept_i && held_q == ST_OK) begin
      if (req_i.ch == CH_NL && line_q != LINE_MAX) begin
        line_d = line_q + 24'd1;
      end

      // Bracket check in normal mode only.
      if (normal) begin
        if (ok_kind != KIND_NONE) begin
          if (sp_q == SPW'(STACK_ENTRIES)) begin
            held_d = ST_OVERFLOW;
          end else begin
            ram_we_o = 1'b1;
            sp_d     = sp_q + SPW'(1);
            top_d    = ok_kind;
          end
        end else if (cl_kind != KIND_NONE) begin
          if (sp_q != '0 && top_q == cl_kind) begin
            sp_d  = sp_q - SPW'(1);
            top_d = ram_rdata_i;
          end else begin
            held_d = ST_MISMATCH;
          end
        end
      end

      // Lexical mode follows the byte unless it raised an error.
      if (held_d == ST_OK) begin
        case (mode_q)
          LEX_SQUOTE: begin
            if (req_i.ch == CH_SQ) mode_d = LEX_NORMAL;
          end
          LEX_DQUOTE: begin
            if (req_i.ch == CH_DQ) mode_d = LEX_NORMAL;
          end
          LEX_DIRECT: begin
            if (req_i.ch == CH_NL) mode_d = LEX_NORMAL;
          end
          LEX_COMMENT: begin
            if (prev_q == CH_STAR && req_i.ch == CH_SLASH) mode_d = LEX_NORMAL;
          end
          default: begin
            if (req_i.ch == CH_DQ) mode_d = LEX_DQUOTE;
            else if (req_i.ch == CH_SQ) mode_d = LEX_SQUOTE;
            else if (prev_q == CH_HASH && req_i.ch == CH_D) mode_d = LEX_DIRECT;
            else if (prev_q == CH_SLASH && req_i.ch == CH_STAR) mode_d = LEX_COMMENT;
            else mode_d = LEX_NORMAL;
          end
        endcase
        prev_d = req_i.ch;
      end
    end

    // Result of this byte.
    status = held_d;
    if (req_i.end_of_text && held_d == ST_OK && sp_d != '0) begin
      status = ST_UNCLOSED;
    end
    res_o.status      = status;
    res_o.line_number = line_d;
    res_o.depth       = 9'(sp_d);

    // The final byte returns the checker to its initial state.
    if (accept_i && req_i.end_of_text) begin
      mode_d = LEX_NORMAL;
      prev_d = CH_SPACE;
      sp_d   = '0;
      line_d = 24'd1;
      held_d = ST_OK;
    end
  end

  // Stack RAM addressing.
  assign ok_kind_w   = opener_kind(req_i.ch);
  assign ram_waddr_o = sp_q[AW-1:0];
  assign ram_wdata_o = ok_kind_w;
  assign ram_raddr_o = AW'(sp_d - SPW'(2));

  // Checker state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= LEX_NORMAL;
      prev_q <= CH_SPACE;
      sp_q   <= '0;
      line_q <= 24'd1;
      held_q <= ST_OK;
      top_q  <= 2'd0;
    end else begin
      mode_q <= mode_d;
      prev_q <= prev_d;
      sp_q   <= sp_d;
      line_q <= line_d;
      held_q <= held_d;
      top_q  <= top_d;
    end
  end

endmodule

### hw/rtl/bbc_out_buf.sv
module bbc_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  bbc_pkg::out_t res_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bbc_pkg::out_t out_data_o
);

  import bbc_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  out_t out_q, out_d;
  out_t skid_q, skid_d;
  logic out_fire;

  assign out_fire = out_valid_q && !out_stall_i;

  // Output register with one skid entry behind it. A new result is only
  // offered while the skid entry is empty.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (res_valid_i) begin
      if (!out_valid_q || out_fire) begin
        out_valid_d = 1'b1;
        out_d       = res_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res_i;
      end
    end else if (out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### bench/balance_monitor.sv
`timescale 1ns / 100ps

module balance_monitor #(
  parameter int STACK_ENTRIES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  bbc_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  bbc_pkg::out_t out_data_i,
  output int unsigned   mismatch_count_o,
  output int unsigned   reports_due_o
);
  import bbc_pkg::*;

  typedef enum logic [2:0] {
    LEX_NORMAL,
    LEX_SQUOTE,
    LEX_DQUOTE,
    LEX_DIRECTIVE,
    LEX_COMMENT
  } lex_mode_e;

  typedef enum logic [1:0] {
    KIND_PAREN,
    KIND_SQUARE,
    KIND_CURLY,
    KIND_NONE
  } bracket_kind_e;

  localparam logic [23:0] LINE_LIMIT = 24'hFFFFFF;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = "\"";
  localparam logic [7:0] CH_SQUOTE = "'";
  localparam logic [7:0] CH_HASH   = "#";
  localparam logic [7:0] CH_D      = "d";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_STAR   = "*";

  // Shadow copy of the lexer, the bracket stack and the line counter.
  lex_mode_e     lex_mode;
  logic [7:0]    last_byte;
  bracket_kind_e open_kinds [STACK_ENTRIES];
  int unsigned   open_count;
  logic [23:0]   line_count;
  logic [1:0]    held_error;

  // Reports predicted for accepted requests, oldest first.
  out_t          reports_q [$];

  function automatic void clear_lexer();
    lex_mode   = LEX_NORMAL;
    last_byte  = 8'h20;
    open_count = 0;
    line_count = 24'd1;
    held_error = ST_OK;
  endfunction

  // Advances the shadow state by one byte and returns the report it causes.
  function automatic out_t next_report(in_t req);
    logic [7:0]    c;
    bracket_kind_e open_kind;
    bracket_kind_e close_kind;
    out_t          report;
    c = req.ch;
    if (held_error == ST_OK) begin
      if (c == CH_NL && line_count < LINE_LIMIT) line_count++;

      // Brackets only count outside quotes, directives and comments.
      if (lex_mode == LEX_NORMAL) begin
        case (c)
          "(":     open_kind = KIND_PAREN;
          "[":     open_kind = KIND_SQUARE;
          "{":     open_kind = KIND_CURLY;
          default: open_kind = KIND_NONE;
        endcase
        case (c)
          ")":     close_kind = KIND_PAREN;
          "]":     close_kind = KIND_SQUARE;
          "}":     close_kind = KIND_CURLY;
          default: close_kind = KIND_NONE;
        endcase
        if (open_kind != KIND_NONE) begin
          if (open_count >= STACK_ENTRIES) begin
            held_error = ST_OVERFLOW;
          end else begin
            open_kinds[open_count] = open_kind;
            open_count++;
          end
        end else if (close_kind != KIND_NONE) begin
          if (open_count != 0 && open_kinds[open_count - 1] == close_kind) begin
            open_count--;
          end else begin
            held_error = ST_MISMATCH;
          end
        end
      end

      // The mode only moves on while no error is held.
      if (held_error == ST_OK) begin
        case (lex_mode)
          LEX_SQUOTE: begin
            if (c == CH_SQUOTE) lex_mode = LEX_NORMAL;
          end
          LEX_DQUOTE: begin
            if (c == CH_DQUOTE) lex_mode = LEX_NORMAL;
          end
          LEX_DIRECTIVE: begin
            if (c == CH_NL) lex_mode = LEX_NORMAL;
          end
          LEX_COMMENT: begin
            if (last_byte == CH_STAR && c == CH_SLASH) lex_mode = LEX_NORMAL;
          end
          default: begin
            if (c == CH_DQUOTE) lex_mode = LEX_DQUOTE;
            else if (c == CH_SQUOTE) lex_mode = LEX_SQUOTE;
            else if (last_byte == CH_HASH && c == CH_D) lex_mode = LEX_DIRECTIVE;
            else if (last_byte == CH_SLASH && c == CH_STAR) lex_mode = LEX_COMMENT;
            else lex_mode = LEX_NORMAL;
          end
        endcase
        last_byte = c;
      end
    end

    report.status = held_error;
    if (req.end_of_text && held_error == ST_OK && open_count != 0) report.status = ST_UNCLOSED;
    report.line_number = line_count;
    report.depth       = 9'(open_count);
    if (req.end_of_text) clear_lexer();
    return report;
  endfunction

  task automatic compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count_o++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Predict on every accepted request and check every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    out_t want;
    if (!rst_ni) begin
      clear_lexer();
      reports_q.delete();
      mismatch_count_o = 0;
      reports_due_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) reports_q.push_back(next_report(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (reports_q.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: no result expected, actual status %0d line %0d depth %0d",
                   $time, out_data_i.status, out_data_i.line_number, out_data_i.depth);
        end else begin
          want = reports_q.pop_front();
          compare_field("status", want.status, out_data_i.status);
          compare_field("line_number", want.line_number, out_data_i.line_number);
          compare_field("depth", want.depth, out_data_i.depth);
        end
      end
      reports_due_o = reports_q.size();
    end
  end

endmodule

### bench/bracket_balance_checker_test.sv
`timescale 1ns / 100ps

module bracket_balance_checker_test;
  import bbc_pkg::*;

  localparam int STACK_ENTRIES  = 256;
  localparam int RANDOM_ITEMS   = 625;
  localparam int HOLD_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum int {
    SHAPE_BALANCED,
    SHAPE_UNCLOSED,
    SHAPE_MISMATCH,
    SHAPE_NOISE,
    SHAPE_DEEP
  } text_shape_e;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] OPEN_CH  [3] = '{"(", "[", "{"};
  localparam logic [7:0] CLOSE_CH [3] = '{")", "]", "}"};

  // Plain code characters, and the looser set used inside quotes and comments.
  localparam string WORD_SET   = "ab_xz09 ;=+-\\";
  localparam string FILLER_SET = "ab z9;*()[]{}\\\t";

  // Directed texts: nested brackets, a closer on an empty stack, an error held
  // over a newline, and brackets hidden by quotes, a directive and a comment.
  localparam logic [7:0] DIRECTED_CH [25] = '{
    "(", "[", "{", "}", "]", ")",
    8'h00, ")",
    "(", "]", CH_NL, "(",
    "\"", "(", "\"", "#", "d", "(", CH_NL, "/", "*", "(", "*", "/", 8'hFF
  };
  localparam logic [24:0] DIRECTED_LAST = (25'd1 << 5) | (25'd1 << 7) | (25'd1 << 11)
                                        | (25'd1 << 24);

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  in_t           in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  out_t          out_data;
  int unsigned   mismatch_count;
  int unsigned   reports_due;

  bit            idle_on     = 1'b1;
  bit            hold_output = 1'b0;
  int unsigned   quiet_cycles = 0;
  logic [7:0]    text_bytes [$];

  always #6 clk = ~clk;

  bracket_balance_checker #(
    .STACK_ENTRIES(STACK_ENTRIES)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  balance_monitor #(
    .STACK_ENTRIES(STACK_ENTRIES)
  ) u_monitor (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatch_count),
    .reports_due_o   (reports_due)
  );

  // The run is stuck if no request and no result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random back-pressure, or one long hold-off when asked for.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_output = 1'b0;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 34);
      end
    end
  end

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // Offers one request from a falling edge and holds it until it is taken.
  task automatic send_byte(input logic [7:0] ch, input logic last);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 34) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= {ch, last};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++) begin
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
    end
  endtask

  // Builds one text of the given shape; all shapes but the deep one use a number of random tokens.
  task automatic build_text(input text_shape_e shape, input int unsigned tokens);
    logic [7:0]  closers [$];
    int unsigned k;
    text_bytes.delete();

    // Enough openers to fill the stack and run past its end.
    if (shape == SHAPE_DEEP) begin
      repeat (STACK_ENTRIES + 2) text_bytes.push_back(OPEN_CH[$urandom_range(0, 2)]);
      text_bytes.push_back(CLOSE_CH[0]);
      return;
    end

    // Any byte at all, with brackets a little more likely.
    if (shape == SHAPE_NOISE) begin
      repeat (tokens * 3) begin
        if ($urandom_range(0, 3) == 0) begin
          text_bytes.push_back($urandom_range(0, 1) ? OPEN_CH[$urandom_range(0, 2)]
                                                    : CLOSE_CH[$urandom_range(0, 2)]);
        end else begin
          text_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      return;
    end

    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          k = $urandom_range(0, 2);
          text_bytes.push_back(OPEN_CH[k]);
          closers.push_back(CLOSE_CH[k]);
        end
        2, 3: begin
          if (shape == SHAPE_MISMATCH && $urandom_range(0, 4) == 0) begin
            text_bytes.push_back(CLOSE_CH[$urandom_range(0, 2)]);
          end else if (closers.size() != 0) begin
            text_bytes.push_back(closers.pop_back());
          end else begin
            text_bytes.push_back(pick_char(WORD_SET));
          end
        end
        4: begin
          text_bytes.push_back("\"");
          repeat ($urandom_range(0, 6)) text_bytes.push_back(pick_char(FILLER_SET));
          text_bytes.push_back("\"");
        end
        5: begin
          text_bytes.push_back("'");
          text_bytes.push_back(pick_char(FILLER_SET));
          text_bytes.push_back("'");
        end
        6: begin
          text_bytes.push_back("/");
          text_bytes.push_back("*");
          repeat ($urandom_range(1, 6)) text_bytes.push_back(pick_char(FILLER_SET));
          text_bytes.push_back("*");
          text_bytes.push_back("/");
        end
        7: begin
          text_bytes.push_back("#");
          text_bytes.push_back("d");
          repeat ($urandom_range(0, 6)) text_bytes.push_back(pick_char(FILLER_SET));
          text_bytes.push_back(CH_NL);
        end
        8: text_bytes.push_back(CH_NL);
        default: text_bytes.push_back(pick_char(WORD_SET));
      endcase
    end

    // Close what is open, except where the text is meant to end unclosed; there, open one bracket if none is open.
    if (shape != SHAPE_UNCLOSED) begin
      while (closers.size() != 0) text_bytes.push_back(closers.pop_back());
    end else if (closers.size() == 0) begin
      text_bytes.push_back(OPEN_CH[$urandom_range(0, 2)]);
    end
  endtask

  initial begin
    text_shape_e shape;
    int unsigned roll;
    int unsigned sent_random;
    bit          deep_done;
    bit          pause_done;
    sent_random = 0;
    deep_done   = 1'b0;
    pause_done  = 1'b0;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < 25; i++) send_byte(DIRECTED_CH[i], DIRECTED_LAST[i]);

    // The result side holds off while the first random texts are offered.
    hold_output = 1'b1;

    while (sent_random < RANDOM_ITEMS) begin
      if (!deep_done && sent_random >= 300) begin
        build_text(SHAPE_DEEP, 0);
        deep_done = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 58) shape = SHAPE_BALANCED;
        else if (roll < 72) shape = SHAPE_UNCLOSED;
        else if (roll < 86) shape = SHAPE_MISMATCH;
        else shape = SHAPE_NOISE;
        build_text(shape, $urandom_range(1, 12));
      end
      idle_on = !(sent_random >= 250 && sent_random < 400);
      send_text();
      sent_random += text_bytes.size();

      // Let the block drain completely once before going on.
      if (!pause_done && sent_random >= 150) begin
        in_valid <= 1'b0;
        @(negedge clk);
        wait (reports_due == 0);
        @(negedge clk);
        pause_done = 1'b1;
      end
    end
    in_valid <= 1'b0;

    wait (reports_due == 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && reports_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_ram.sv
hw/rtl/bbc_core.sv
hw/rtl/bbc_out_buf.sv
hw/rtl/bracket_balance_checker.sv
bench/balance_monitor.sv
bench/bracket_balance_checker_test.sv
